### rtl/core/tdpt_pkg.sv
// Package for the trial division prime test block.
// Holds the shared widths, divisor constants and the remainder unit status type.
// No dependencies.
package tdpt_pkg;

   // Width of the number under test.
   localparam int unsigned VALUE_WIDTH = 32;
   // Candidate divisors run up to 65537, so they need 17 bits.
   localparam int unsigned DIV_WIDTH = 17;
   // Width of the square of the low 16 divisor bits.
   localparam int unsigned SQ_WIDTH = 32;
   // Width of the iteration counter inside the remainder unit.
   localparam int unsigned CNT_WIDTH = $clog2(VALUE_WIDTH);

   localparam logic [DIV_WIDTH-1:0] DIVISOR_THREE = DIV_WIDTH'(3);
   localparam logic [DIV_WIDTH-1:0] DIVISOR_FIRST = DIV_WIDTH'(5);
   localparam logic [DIV_WIDTH-1:0] DIVISOR_PAIR  = DIV_WIDTH'(2);
   localparam logic [DIV_WIDTH-1:0] DIVISOR_STEP  = DIV_WIDTH'(6);

   // Status of the shared remainder unit as seen by the sequencer.
   typedef struct packed {
      logic busy;   // a remainder is being worked out
      logic done;   // one-cycle pulse when the remainder is ready
      logic zero;   // remainder is zero, valid with done
   } rem_status_type;

endpackage

### rtl/core/trial_division_prime_test_top.sv
// Top level of the trial division prime test block.
// Holds the sequencer, the divisor square register and the assertions.
// Depends on tdpt_pkg and tdpt_rem.

// A transaction starts when start is high while busy is low; req_value is taken then.
// Values below 2, 2, 3 and even values answer in the next cycle. Any other value runs
// through one shared serial remainder unit: first a test by 3, then for each divisor
// pair d, d+2 a square, a compare and two remainders, while d*d <= value. The worst
// case, a large prime, takes 10922 pairs. The answer appears on rsp_is_prime for exactly
// one cycle with rsp_valid high and must be taken then; busy is already low in that
// cycle, so the next transaction may start at once.
module trial_division_prime_test_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tdpt_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                rsp_valid,
   output logic                                rsp_is_prime
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MOD3 = 3'd1;
   localparam logic [2:0] ST_SQ   = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_MODA = 3'd4;
   localparam logic [2:0] ST_MODB = 3'd5;

   logic [2:0]                         state_ff, state_in;
   logic [tdpt_pkg::VALUE_WIDTH-1:0]   n_ff, n_in;
   logic [tdpt_pkg::DIV_WIDTH-1:0]     d_ff, d_in;
   logic [tdpt_pkg::SQ_WIDTH-1:0]      sq_ff, sq_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_is_prime_ff, rsp_is_prime_in;
   logic                               accept;
   logic                               rem_go;
   logic [tdpt_pkg::VALUE_WIDTH-1:0]   rem_dividend;
   logic [tdpt_pkg::DIV_WIDTH-1:0]     rem_divisor;
   tdpt_pkg::rem_status_type           rem_stat;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // The number comes straight from the port on the first remainder.
   assign rem_dividend = (state_ff == ST_IDLE) ? req_value : n_ff;

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      d_in            = d_ff;
      sq_in           = sq_ff;
      rsp_valid_in    = 1'b0;
      rsp_is_prime_in = rsp_is_prime_ff;
      rem_go          = 1'b0;
      rem_divisor     = tdpt_pkg::DIVISOR_THREE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in = req_value;
               if (req_value < tdpt_pkg::VALUE_WIDTH'(2)) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
               end else if (req_value == tdpt_pkg::VALUE_WIDTH'(2) ||
                            req_value == tdpt_pkg::VALUE_WIDTH'(3)) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b1;
               end else if (!req_value[0]) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
               end else begin
                  rem_go      = 1'b1;
                  rem_divisor = tdpt_pkg::DIVISOR_THREE;
                  state_in    = ST_MOD3;
               end
            end
         end
         ST_MOD3: begin
            if (rem_stat.done) begin
               if (rem_stat.zero) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
                  state_in        = ST_IDLE;
               end else begin
                  d_in     = tdpt_pkg::DIVISOR_FIRST;
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            // Past 65535 no further divisor can matter.
            if (d_ff[tdpt_pkg::DIV_WIDTH-1]) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               sq_in    = {16'b0, d_ff[15:0]} * {16'b0, d_ff[15:0]};
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sq_ff > n_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               rem_go      = 1'b1;
               rem_divisor = d_ff;
               state_in    = ST_MODA;
            end
         end
         ST_MODA: begin
            rem_divisor = d_ff + tdpt_pkg::DIVISOR_PAIR;
            if (rem_stat.done) begin
               if (rem_stat.zero) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
                  state_in        = ST_IDLE;
               end else begin
                  rem_go   = 1'b1;
                  state_in = ST_MODB;
               end
            end
         end
         ST_MODB: begin
            if (rem_stat.done) begin
               if (rem_stat.zero) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
                  state_in        = ST_IDLE;
               end else begin
                  d_in     = d_ff + tdpt_pkg::DIVISOR_STEP;
                  state_in = ST_SQ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      d_ff            <= d_in;
      sq_ff           <= sq_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   // Shared serial remainder unit.
   tdpt_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .go       (rem_go),
      .dividend (rem_dividend),
      .divisor  (rem_divisor),
      .status   (rem_stat)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // An accepted transaction either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted transaction neither answered nor busy");

   // The remainder unit is never restarted while it works.
   a_rem_go_idle: assert property (@(posedge clock) disable iff (reset)
      rem_go |-> !rem_stat.busy)
      else $error("remainder unit started while busy");

   // A finished remainder only arrives while the sequencer waits for one.
   a_rem_done_wait: assert property (@(posedge clock) disable iff (reset)
      rem_stat.done |-> (state_ff == ST_MOD3 || state_ff == ST_MODA ||
                         state_ff == ST_MODB))
      else $error("remainder finished outside a wait state");

   // The divisor never runs past 65537.
   a_divisor_bound: assert property (@(posedge clock) disable iff (reset)
      (busy && d_ff[tdpt_pkg::DIV_WIDTH-1]) |-> (d_ff[tdpt_pkg::DIV_WIDTH-2:1] == '0))
      else $error("divisor beyond its last value");

endmodule

### rtl/core/tdpt_rem.sv
// Serial remainder unit for the trial division prime test block.
// Restoring division, one dividend bit per cycle; reports only whether the remainder is zero.
// Depends on tdpt_pkg.
module tdpt_rem (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic [tdpt_pkg::VALUE_WIDTH-1:0]    dividend,
   input  logic [tdpt_pkg::DIV_WIDTH-1:0]      divisor,
   output tdpt_pkg::rem_status_type            status
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic                               zero_ff, zero_in;
   logic [tdpt_pkg::CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [tdpt_pkg::VALUE_WIDTH-1:0]   shf_ff, shf_in;
   logic [tdpt_pkg::DIV_WIDTH-1:0]     rem_ff, rem_in;
   logic [tdpt_pkg::DIV_WIDTH-1:0]     div_ff, div_in;
   logic [tdpt_pkg::DIV_WIDTH:0]       shifted;
   logic [tdpt_pkg::DIV_WIDTH:0]       diff;

   // One restoring step: bring in the next dividend bit and subtract if it fits.
   assign shifted = {rem_ff, shf_ff[tdpt_pkg::VALUE_WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      shf_in  = shf_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         shf_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         shf_in = {shf_ff[tdpt_pkg::VALUE_WIDTH-2:0], 1'b0};
         if (!diff[tdpt_pkg::DIV_WIDTH]) begin
            rem_in = diff[tdpt_pkg::DIV_WIDTH-1:0];
         end else begin
            rem_in = shifted[tdpt_pkg::DIV_WIDTH-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         // The last dividend bit has gone in: report the result.
         if (cnt_ff == tdpt_pkg::CNT_WIDTH'(tdpt_pkg::VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            zero_in = (rem_in == '0);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      shf_ff  <= shf_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.zero = zero_ff;

endmodule

### verif/trial_division_prime_test_top_tb.sv
// Self-checking testbench for trial_division_prime_test_top.
// Drives directed and random numbers and compares each answer with a local primality predictor.
// Depends on tdpt_pkg and the trial_division_prime_test_top RTL.
`timescale 1ns / 100ps

module trial_division_prime_test_top_tb;

   // Upper bound on the first divisor of each pair the block tries.
   localparam int unsigned DIVISOR_CEILING = 65535;
   // Cost cap for random numbers, in divisor pairs tried.
   localparam int unsigned PAIR_CAP = 250;
   // Cycles without any transaction before the run is given up.
   localparam int unsigned STALL_LIMIT = 3000000;
   // Cycles to watch for stray answers once everything has arrived.
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned RANDOM_ITEMS = 100;

   // Scoreboard: predicts the answer for each accepted number and checks answers in order.
   class primality_scoreboard;
      logic [tdpt_pkg::VALUE_WIDTH-1:0] value_q[$];
      bit                               prime_q[$];
      int unsigned                      failures;

      // Trial division by 3 and the pairs 6k-1, 6k+1; pairs counts the pairs tried.
      function automatic bit predict_prime(input logic [tdpt_pkg::VALUE_WIDTH-1:0] n,
                                           output int unsigned pairs);
         logic [63:0] d;
         pairs = 0;
         if (n < 2) return 1'b0;
         if (n == 2 || n == 3) return 1'b1;
         if (!n[0] || (n % 3) == 0) return 1'b0;
         for (d = 5; d <= DIVISOR_CEILING && d * d <= 64'(n); d += 6) begin
            pairs++;
            if ((64'(n) % d) == 0 || (64'(n) % (d + 2)) == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(input logic [tdpt_pkg::VALUE_WIDTH-1:0] n);
         int unsigned pairs;
         value_q.push_back(n);
         prime_q.push_back(predict_prime(n, pairs));
      endfunction

      function void check_result(input logic got);
         logic [tdpt_pkg::VALUE_WIDTH-1:0] n;
         bit                               want;
         if (prime_q.size() == 0) begin
            $display("%0t: answer %b arrived with no transaction outstanding", $time, got);
            failures++;
            return;
         end
         n    = value_q.pop_front();
         want = prime_q.pop_front();
         if (got !== want) begin
            $display("%0t: value %0d: is_prime expected %b, actual %b", $time, n, want, got);
            failures++;
         end
      endfunction

      function int unsigned outstanding();
         return prime_q.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [tdpt_pkg::VALUE_WIDTH-1:0] req_value;
   logic                             rsp_valid;
   logic                             rsp_is_prime;

   primality_scoreboard    sb;
   bit                     take_now;
   bit                     answer_now;
   int unsigned            quiet_cycles;

   trial_division_prime_test_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Handshakes are sampled mid-cycle, where every signal is settled for the coming edge.
   always @(negedge clock) begin
      take_now   = !reset && start && !busy;
      answer_now = !reset && rsp_valid;
      if (take_now) sb.note_request(req_value);
      if (answer_now) sb.check_result(rsp_is_prime);
   end

   // Watchdog: give up when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || take_now || answer_now) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("trial_division_prime_test_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one number and hold it until the block takes it. Start stays high on return.
   task automatic send_number(input logic [tdpt_pkg::VALUE_WIDTH-1:0] n);
      start     <= 1'b1;
      req_value <= n;
      do @(posedge clock); while (!take_now);
   endtask

   // Sender gap; the value bus carries noise meanwhile.
   task automatic hold_off(input int unsigned cycles);
      start     <= 1'b0;
      req_value <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending until every outstanding answer has come back.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Pick a random number whose trial division stays short.
   task automatic pick_number(output logic [tdpt_pkg::VALUE_WIDTH-1:0] n);
      int unsigned pairs;
      int unsigned width;
      int unsigned a;
      int unsigned b;
      do begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // Small value of random bit length.
               width = $urandom_range(1, 18);
               n     = tdpt_pkg::VALUE_WIDTH'($urandom & ((33'd1 << width) - 1));
            end
            4, 5: begin
               // Odd and not a multiple of 3, so it reaches the divisor loop.
               n = 6 * $urandom_range(0, 20000) + ($urandom_range(0, 1) ? 1 : 5);
            end
            6: begin
               // Product of two candidates of the form 6k-1 or 6k+1.
               a = 6 * $urandom_range(1, 250) + ($urandom_range(0, 1) ? 1 : -1);
               b = 6 * $urandom_range(1, 250) + ($urandom_range(0, 1) ? 1 : -1);
               n = a * b;
            end
            default: begin
               // Full-width value; only cheap ones pass the cost cap.
               n = $urandom;
            end
         endcase
         void'(sb.predict_prime(n, pairs));
      end while (pairs > PAIR_CAP);
   endtask

   // Directed numbers: edges of the range, tiny primes and composites, squares of primes.
   logic [tdpt_pkg::VALUE_WIDTH-1:0] directed_numbers[] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd25, 32'd35,
      32'd49, 32'd121, 32'd143, 32'd997, 32'd9409, 32'd65535, 32'd65537,
      32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAB,
      32'd4294967291
   };

   initial begin
      logic [tdpt_pkg::VALUE_WIDTH-1:0] n;
      int unsigned                      sent;
      int unsigned                      burst;
      int unsigned                      gap;

      sb           = new;
      quiet_cycles = 0;
      take_now     = 1'b0;
      answer_now   = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_value    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, back to back with an occasional gap.
      foreach (directed_numbers[i]) begin
         send_number(directed_numbers[i]);
         if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 4));
      end
      drain();

      // Random part in bursts with random gaps; some bursts run without gaps.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 8);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            pick_number(n);
            send_number(n);
            sent++;
            if (sent == RANDOM_ITEMS / 2) drain();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) hold_off(gap);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("trial_division_prime_test_top_tb OK");
      end else begin
         $display("trial_division_prime_test_top_tb NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_rem.sv
rtl/core/trial_division_prime_test_top.sv
verif/trial_division_prime_test_top_tb.sv
